// ===== rtl/core/arp_cache_table_assert.svh =====
// Assertion macros used by the ARP cache scan engine.
`ifndef ARP_CACHE_TABLE_ASSERT_SVH
`define ARP_CACHE_TABLE_ASSERT_SVH

// Checks cons in the same cycle whenever ante holds; needs clk and rst_n in scope.
`define ARPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpc assertion failed");

// Checks cons in the cycle after ante holds.
`define ARPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpc assertion failed");

`endif

// ===== rtl/core/arpc_pkg.sv =====
// Shared types and constants of the ARP cache table.
`default_nettype none

package arpc_pkg;

    localparam int SLOTS            = 4;
    localparam int PORTS_PER_SLOT   = 4;
    localparam int ENTRIES_PER_PORT = 16;

    localparam int TOTAL_ENTRIES = SLOTS * PORTS_PER_SLOT * ENTRIES_PER_PORT;
    localparam int ADDR_W        = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int TAG_W = 8;

    localparam int IN_DATA_W  = ((IP_W + MAC_W + 3 * TAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MAC_W + 3 * TAG_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [TAG_W-1:0] port;
        logic [TAG_W-1:0] slot;
        logic [TAG_W-1:0] kind;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_MISS      = 3'd0,
        ST_HIT       = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_REFRESHED = 3'd4,
        ST_INSERTED  = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_UPDATE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] port;
        logic [TAG_W-1:0] slot;
        logic [TAG_W-1:0] kind;
        logic [MAC_W-1:0] mac;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/arpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/arpc_store.sv =====
// Entry store: the entry RAM plus per-entry written flags that make unwritten entries read as free.
`default_nettype none

module arpc_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire arpc_pkg::mem_req_t req,
    output arpc_pkg::entry_t        rd_entry
);

    import arpc_pkg::*;

    logic [TOTAL_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;
    logic [ENTRY_W-1:0]       ram_q;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // An entry never written since reset reads as all zero, which is a free entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? entry_t'(ram_q) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/arpc_engine.sv =====
// Scan engine: walks the store one entry per cycle for lookups and bank updates.
`default_nettype none
`include "arp_cache_table_assert.svh"

module arpc_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire arpc_pkg::opcode_t  in_op,
    input  wire arpc_pkg::entry_t   in_entry,
    output arpc_pkg::mem_req_t      mem_req,
    input  wire arpc_pkg::entry_t   rd_entry,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output arpc_pkg::result_t       result
);

    import arpc_pkg::*;

    eng_state_t state_reg, state_next;
    opcode_t    op_reg, op_next;
    entry_t     key_reg, key_next;
    addr_t      iss_addr_reg, iss_addr_next;
    logic       iss_active_reg, iss_active_next;
    addr_t      last_addr_reg, last_addr_next;
    addr_t      ovf_addr_reg, ovf_addr_next;
    logic       chk_valid_reg, chk_valid_next;
    addr_t      chk_addr_reg, chk_addr_next;
    logic       chk_last_reg, chk_last_next;
    logic       free_found_reg, free_found_next;
    addr_t      free_addr_reg, free_addr_next;
    result_t    res_reg, res_next;

    logic  bank_ok;
    addr_t bank_base;
    addr_t bank_last;
    addr_t bank_ovf;
    logic  entry_hit;
    logic  entry_free;

    assign bank_ok = (in_entry.slot < TAG_W'(SLOTS)) && (in_entry.port < TAG_W'(PORTS_PER_SLOT));
    assign bank_base = ADDR_W'((int'(in_entry.slot) * PORTS_PER_SLOT + int'(in_entry.port))
                               * ENTRIES_PER_PORT);
    assign bank_last = bank_base + ADDR_W'(ENTRIES_PER_PORT - 1);
    assign bank_ovf  = ADDR_W'((int'(in_entry.slot) * PORTS_PER_SLOT + PORTS_PER_SLOT - 1)
                               * ENTRIES_PER_PORT + ENTRIES_PER_PORT - 1);

    assign entry_hit  = (rd_entry.ip != '0) && (rd_entry.ip == key_reg.ip);
    assign entry_free = (rd_entry.ip == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_active_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_active_reg <= iss_active_next;
            chk_valid_reg  <= chk_valid_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        iss_addr_reg  <= iss_addr_next;
        last_addr_reg <= last_addr_next;
        ovf_addr_reg  <= ovf_addr_next;
        chk_addr_reg  <= chk_addr_next;
        chk_last_reg  <= chk_last_next;
        free_addr_reg <= free_addr_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        iss_addr_next   = iss_addr_reg;
        iss_active_next = iss_active_reg;
        last_addr_next  = last_addr_reg;
        ovf_addr_next   = ovf_addr_reg;
        free_found_next = free_found_reg;
        free_addr_next  = free_addr_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = (state_reg == S_DONE);

        mem_req         = '0;
        mem_req.rd_addr = iss_addr_reg;
        mem_req.rd_en   = iss_active_reg && (state_reg == S_SCAN);
        mem_req.wr_data = key_reg;

        // Read issue runs one address ahead of the compare stage.
        if (mem_req.rd_en)
        begin
            iss_addr_next = iss_addr_reg + 1'b1;
            if (iss_addr_reg == last_addr_reg)
            begin
                iss_active_next = 1'b0;
            end
        end
        chk_valid_next = mem_req.rd_en;
        chk_addr_next  = iss_addr_reg;
        chk_last_next  = (iss_addr_reg == last_addr_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = in_op;
                    key_next        = in_entry;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    res_next.status = ST_MISS;
                    if (in_op == OP_LOOKUP)
                    begin
                        iss_addr_next   = '0;
                        last_addr_next  = ADDR_W'(TOTAL_ENTRIES - 1);
                        iss_active_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else if (!bank_ok)
                    begin
                        res_next.status = ST_REJECTED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        iss_addr_next   = bank_base;
                        last_addr_next  = bank_last;
                        ovf_addr_next   = bank_ovf;
                        iss_active_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (chk_valid_reg)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        if (entry_hit)
                        begin
                            res_next.status = ST_HIT;
                            res_next.mac    = rd_entry.mac;
                            res_next.kind   = rd_entry.kind;
                            res_next.slot   = rd_entry.slot;
                            res_next.port   = rd_entry.port;
                            state_next      = S_DONE;
                        end
                        else if (chk_last_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (entry_hit)
                    begin
                        if (rd_entry.mac == key_reg.mac)
                        begin
                            res_next.status = ST_UNCHANGED;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = chk_addr_reg;
                            res_next.status = ST_REFRESHED;
                        end
                        state_next = S_DONE;
                    end
                    else if (chk_last_reg)
                    begin
                        // Whole bank seen without a match: first free entry, else overflow.
                        mem_req.wr_en = 1'b1;
                        if (free_found_reg)
                        begin
                            mem_req.wr_addr = free_addr_reg;
                            res_next.status = ST_INSERTED;
                        end
                        else if (entry_free)
                        begin
                            mem_req.wr_addr = chk_addr_reg;
                            res_next.status = ST_INSERTED;
                        end
                        else
                        begin
                            mem_req.wr_addr = ovf_addr_reg;
                            res_next.status = ST_OVERFLOW;
                        end
                        state_next = S_DONE;
                    end
                    else if (entry_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_addr_next  = chk_addr_reg;
                    end
                end
                if (state_next == S_DONE)
                begin
                    iss_active_next = 1'b0;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result = res_reg;

    `ARPC_ASSERT_NOW(a_wr_only_in_scan, mem_req.wr_en, state_reg == S_SCAN)
    `ARPC_ASSERT_NOW(a_wr_only_on_update, mem_req.wr_en, op_reg == OP_UPDATE)
    `ARPC_ASSERT_NOW(a_hit_only_on_lookup, res_valid && (result.status == ST_HIT), op_reg == OP_LOOKUP)
    `ARPC_ASSERT_NEXT(a_last_compare_ends_scan, (state_reg == S_SCAN) && chk_valid_reg && chk_last_reg, state_reg == S_DONE)

endmodule

`default_nettype wire

// ===== rtl/core/arp_cache_table.sv =====
// Top level of the ARP cache table: stream ports, entry store, scan engine and output register.
//
// Input words arrive on the s_ channel: s_tuser carries the opcode (lookup or update) and
// s_tdata the IP, MAC, port kind, slot and port. Each word produces exactly one result word
// on the m_ channel: m_tuser carries the status, m_tdata the matching entry's fields.
// The block handles one word at a time. Entries sit in a single RAM with one read port, read
// one entry per cycle, so a lookup walks up to all TOTAL_ENTRIES entries (256) and finishes
// earlier on a hit. An update scans only its own bank of ENTRIES_PER_PORT entries (16) and
// stops early when the IP is found, and a bank number out of range is answered without a
// scan. The result passes through the engine's result register and then the output register
// before it appears on m_tvalid.
// Reset marks every entry free at once through per-entry written flags; no clearing pass
// is needed and a word can be accepted as soon as reset is released.
// The result sits in an output register; while m_tready is low it holds there, the engine
// keeps its finished result, and s_tready stays low until the output register frees up.
`default_nettype none

module arp_cache_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // ip_address[31:0], mac_address[79:32], port_kind[87:80], slot_id[95:88], port_id[103:96]
    input  wire logic [arpc_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode[0]
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // found_mac[47:0], found_port_kind[55:48], found_slot[63:56], found_port[71:64]
    output logic      [arpc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic      [2:0]                         m_tuser
);

    import arpc_pkg::*;

    entry_t   in_entry;
    opcode_t  in_op;
    mem_req_t mem_req;
    entry_t   rd_entry;
    logic     res_valid;
    logic     res_ready;
    result_t  result;

    logic    out_valid_reg;
    result_t out_res_reg;

    assign in_op         = opcode_t'(s_tuser[0]);
    assign in_entry.ip   = s_tdata[IP_W-1:0];
    assign in_entry.mac  = s_tdata[IP_W+MAC_W-1:IP_W];
    assign in_entry.kind = s_tdata[IP_W+MAC_W+TAG_W-1:IP_W+MAC_W];
    assign in_entry.slot = s_tdata[IP_W+MAC_W+2*TAG_W-1:IP_W+MAC_W+TAG_W];
    assign in_entry.port = s_tdata[IP_W+MAC_W+3*TAG_W-1:IP_W+MAC_W+2*TAG_W];

    arpc_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    arpc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_entry  (in_entry),
        .mem_req   (mem_req),
        .rd_entry  (rd_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = OUT_DATA_W'({out_res_reg.port, out_res_reg.slot,
                                   out_res_reg.kind, out_res_reg.mac});

endmodule

`default_nettype wire
